FILE: rtl/core/jfps_pkg.sv
// Shared types and constants for the five-point Jacobi stencil.
package jfps_pkg;

   // Configuration register file
   localparam int CFG_WIDTH       = 11;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GRID_ROWS = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GRID_COLS = 1'b1;
   localparam logic [CFG_WIDTH-1:0] DIM_RESET = 11'd1024;
   localparam logic [CFG_WIDTH-1:0] DIM_MIN   = 11'd3;

   // Running sum of relaxed values, wraps
   localparam int SUM_WIDTH = 52;

   // Depth of the queue between front and back (power of two)
   localparam int QUEUE_DEPTH = 4;

   // Classification of one cell, decided by the front
   typedef struct packed {
      logic emit_main;   // emits the relaxed value of the cell one row up
      logic interior;    // that cell is interior, compute the quarter sum
      logic emit_zero;   // last row: also emits this cell's zero
      logic last;        // last column of a row
      logic first;       // cell (0, 0): running sum restarts
   } cell_flags_type;

   localparam int FLAGS_WIDTH = $bits(cell_flags_type);

endpackage

FILE: rtl/core/jfps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module jfps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, old data on a same-address collision
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/jfps_queue.sv
// Short request queue between the classifying front and the compute back.
module jfps_queue
   import jfps_pkg::*;
#(
   parameter int WIDTH = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_FULL);
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTH
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CNT_FULL) |-> !push)
      else $error("queue pushed while full");
`endif

endmodule

FILE: rtl/core/jfps_front.sv
// Front: configuration registers, grid position tracking and cell classification.
module jfps_front
   import jfps_pkg::*;
#(
   parameter int MAX_ROWS    = 1024,
   parameter int MAX_COLS    = 1024,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_wdata,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [VALUE_WIDTH-1:0]     req_temperature,
   input  logic                       req_grid_start,
   output logic                       q_push,
   input  logic                       q_full,
   output logic [VALUE_WIDTH-1:0]     q_value,
   output logic [$clog2(MAX_COLS)-1:0] q_col,
   output cell_flags_type             q_flags
);

   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam int COL_W = $clog2(MAX_COLS);
   localparam int RDW = ($clog2(MAX_ROWS + 1) > CFG_WIDTH) ? $clog2(MAX_ROWS + 1) : CFG_WIDTH;
   localparam int CDW = ($clog2(MAX_COLS + 1) > CFG_WIDTH) ? $clog2(MAX_COLS + 1) : CFG_WIDTH;
   localparam logic [RDW-1:0] ROWS_MAX = RDW'(MAX_ROWS);
   localparam logic [CDW-1:0] COLS_MAX = CDW'(MAX_COLS);

   logic [CFG_WIDTH-1:0] grid_rows_ff, grid_rows_in;
   logic [CFG_WIDTH-1:0] grid_cols_ff, grid_cols_in;
   logic [RDW-1:0]       rows_raw, rows_eff, rows_m1;
   logic [CDW-1:0]       cols_raw, cols_eff, cols_m1;
   logic [ROW_W-1:0]     row_ff, row_in, row_cur;
   logic [COL_W-1:0]     col_ff, col_in, col_cur;
   logic                 restart;
   logic                 row_last;
   logic                 col_last;

   // Configuration writes
   always_comb begin
      grid_rows_in = grid_rows_ff;
      grid_cols_in = grid_cols_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_GRID_ROWS: grid_rows_in = csr_wdata;
            REG_GRID_COLS: grid_cols_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= DIM_RESET;
         grid_cols_ff <= DIM_RESET;
      end else begin
         grid_rows_ff <= grid_rows_in;
         grid_cols_ff <= grid_cols_in;
      end
   end

   // Clamp dimensions to [3, MAX]
   always_comb begin
      rows_raw = RDW'(grid_rows_ff);
      cols_raw = CDW'(grid_cols_ff);
      if (rows_raw < RDW'(DIM_MIN)) begin
         rows_eff = RDW'(DIM_MIN);
      end else if (rows_raw > ROWS_MAX) begin
         rows_eff = ROWS_MAX;
      end else begin
         rows_eff = rows_raw;
      end
      if (cols_raw < CDW'(DIM_MIN)) begin
         cols_eff = CDW'(DIM_MIN);
      end else if (cols_raw > COLS_MAX) begin
         cols_eff = COLS_MAX;
      end else begin
         cols_eff = cols_raw;
      end
      rows_m1 = rows_eff - RDW'(1);
      cols_m1 = cols_eff - CDW'(1);
   end

   // Position of this cell, with restart on grid_start or out-of-range position
   always_comb begin
      restart  = req_grid_start || (RDW'(row_ff) >= rows_eff) || (CDW'(col_ff) >= cols_eff);
      row_cur  = restart ? '0 : row_ff;
      col_cur  = restart ? '0 : col_ff;
      row_last = (RDW'(row_cur) == rows_m1);
      col_last = (CDW'(col_cur) == cols_m1);
   end

   // Classification
   always_comb begin
      q_flags.emit_main = (row_cur != '0);
      q_flags.interior  = (row_cur >= ROW_W'(2)) && (col_cur != '0) && !col_last;
      q_flags.emit_zero = row_last;
      q_flags.last      = col_last;
      q_flags.first     = (row_cur == '0) && (col_cur == '0);
   end

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;
   assign q_value    = req_temperature;
   assign q_col      = col_cur;

   // Next position, raster order with wrap at the end of the grid
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (q_push) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_cur + 1'b1;
         end else begin
            col_in = col_cur + 1'b1;
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

`ifndef SYNTH
   a_wrap_to_origin: assert property (@(posedge clock) disable iff (reset)
      (q_push && row_last && col_last) |=> (row_ff == '0) && (col_ff == '0))
      else $error("position did not wrap after the last cell");
`endif

endmodule

FILE: rtl/core/jfps_back.sv
// Back: line stores, quarter-sum stage, running sum and result sequencing.
module jfps_back
   import jfps_pkg::*;
#(
   parameter int MAX_COLS    = 1024,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   output logic                        q_pop,
   input  logic [VALUE_WIDTH-1:0]      q_value,
   input  logic [$clog2(MAX_COLS)-1:0] q_col,
   input  cell_flags_type              q_flags,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [VALUE_WIDTH-1:0]      rsp_new_temperature,
   output logic [SUM_WIDTH-1:0]        rsp_grid_sum,
   output logic                        rsp_tlast
);

   localparam int COL_W = $clog2(MAX_COLS);
   localparam int W     = VALUE_WIDTH;
   localparam int QW    = VALUE_WIDTH + 2;
   localparam logic [COL_W-1:0] COL_TOP = COL_W'(MAX_COLS - 1);

   // Stage 2: line store data arrives
   logic                 s2_valid_ff, s2_valid_in;
   logic [W-1:0]         s2_value_ff;
   logic [COL_W-1:0]     s2_col_ff;
   cell_flags_type       s2_flags_ff;
   logic [W-1:0]         left_ff;
   // Stage 3: results waiting for the output register
   logic                 s3_main_ff, s3_main_in;
   logic                 s3_zero_ff, s3_zero_in;
   logic                 s3_last_ff;
   logic [W-1:0]         s3_val_ff;
   // Output register and running sum
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]         rsp_val_ff;
   logic [SUM_WIDTH-1:0] rsp_sum_ff;
   logic                 rsp_last_ff;
   logic [SUM_WIDTH-1:0] sum_ff, sum_in, sum_new;

   logic                 pop, s2_adv, s3_take, out_free, load, load_last;
   logic [W-1:0]         load_val;
   logic [2*W-1:0]       m_rd;
   logic [W-1:0]         r_rd;
   logic [W-1:0]         above, two_above;
   logic [COL_W-1:0]     right_addr;
   logic [QW-1:0]        quad_sum;
   logic [W-1:0]         relaxed;

   // Handshake between stages
   always_comb begin
      out_free = !rsp_valid_ff || rsp_tready;
      s3_take  = (!s3_main_ff && !s3_zero_ff) || (out_free && !(s3_main_ff && s3_zero_ff));
      s2_adv   = s2_valid_ff && s3_take;
      pop      = q_valid && (!s2_valid_ff || s3_take);
   end

   assign q_pop = pop;

   // Line stores: {row two above, row above} per column, and a copy of the row
   // above read one column ahead for the right neighbor
   assign right_addr = (q_col == COL_TOP) ? '0 : q_col + 1'b1;

   jfps_ram #(
      .WIDTH (2 * W),
      .DEPTH (MAX_COLS)
   ) u_pair_store (
      .clock   (clock),
      .wr_en   (s2_adv),
      .wr_addr (s2_col_ff),
      .wr_data ({above, s2_value_ff}),
      .rd_en   (pop),
      .rd_addr (q_col),
      .rd_data (m_rd)
   );

   jfps_ram #(
      .WIDTH (W),
      .DEPTH (MAX_COLS)
   ) u_ahead_store (
      .clock   (clock),
      .wr_en   (pop),
      .wr_addr (q_col),
      .wr_data (q_value),
      .rd_en   (pop),
      .rd_addr (right_addr),
      .rd_data (r_rd)
   );

   // Stage 2 registers
   assign s2_valid_in = pop ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s2_value_ff <= q_value;
         s2_col_ff   <= q_col;
         s2_flags_ff <= q_flags;
      end
      if (s2_adv) begin
         left_ff <= above;
      end
   end

   // Quarter sum: floor((up + down + left + right) / 4)
   always_comb begin
      above     = m_rd[W-1:0];
      two_above = m_rd[2*W-1:W];
      quad_sum  = QW'($signed(two_above)) + QW'($signed(s2_value_ff))
                + QW'($signed(left_ff)) + QW'($signed(r_rd));
      relaxed   = s2_flags_ff.interior ? quad_sum[QW-1:2] : '0;
   end

   // Result selection: relaxed value first, then the last-row zero
   always_comb begin
      load      = out_free && (s3_main_ff || s3_zero_ff);
      load_val  = s3_main_ff ? s3_val_ff : '0;
      load_last = !s3_main_ff && s3_last_ff;
      sum_new   = sum_ff + SUM_WIDTH'($signed(load_val));
   end

   // Stage 3 and running sum
   always_comb begin
      s3_main_in = s3_main_ff;
      s3_zero_in = s3_zero_ff;
      sum_in     = load ? sum_new : sum_ff;
      if (s2_adv) begin
         s3_main_in = s2_flags_ff.emit_main;
         s3_zero_in = s2_flags_ff.emit_zero;
         if (s2_flags_ff.first) begin
            sum_in = '0;
         end
      end else if (load) begin
         s3_main_in = 1'b0;
         s3_zero_in = s3_main_ff && s3_zero_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_main_ff <= 1'b0;
         s3_zero_ff <= 1'b0;
         sum_ff     <= '0;
      end else begin
         s3_main_ff <= s3_main_in;
         s3_zero_ff <= s3_zero_in;
         sum_ff     <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         s3_val_ff  <= relaxed;
         s3_last_ff <= s2_flags_ff.last;
      end
   end

   // Output register
   assign rsp_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_val_ff  <= load_val;
         rsp_sum_ff  <= load_last ? sum_new : '0;
         rsp_last_ff <= load_last;
      end
   end

   assign rsp_tvalid          = rsp_valid_ff;
   assign rsp_new_temperature = rsp_val_ff;
   assign rsp_grid_sum        = rsp_sum_ff;
   assign rsp_tlast           = rsp_last_ff;

`ifndef SYNTH
   a_last_is_edge: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_val_ff == '0))
      else $error("final result of a grid is not an edge zero");

   a_sum_only_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (rsp_sum_ff == '0))
      else $error("grid sum shown on a non-final result");

   a_store_collision: assert property (@(posedge clock) disable iff (reset)
      (pop && s2_adv && (q_col == s2_col_ff)) |-> (q_col == '0))
      else $error("line store read and write collide off column zero");
`endif

endmodule

FILE: rtl/core/jacobi_five_point_stencil.sv
// Top level of the streaming five-point Jacobi relaxation sweep.
//
//   port group  dir  payload
//   req_*       in   tdata: temperature; tuser: grid_start
//   rsp_*       out  tdata: new_temperature, grid_sum; tlast: last_of_grid
//   csr_*       in   index 0 grid_rows, index 1 grid_cols (11 bits each)
//
// One request per cycle while the queue is not full; a last-row request yields two
// responses. A request passes through the queue, the line-store read stage, the
// result stage and the response register, in that order. Reset is synchronous,
// loads the default grid size and clears position, sum and handshake state; line
// stores are not cleared (the first two rows of a grid never read them). A
// four-entry queue lets requests flow while responses stall.
module jacobi_five_point_stencil
   import jfps_pkg::*;
#(
   parameter int MAX_COLS    = 1024,
   parameter int MAX_ROWS    = 1024,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   // configuration
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_wdata,
   // requests
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,  // [0] temperature
   input  logic                       req_tuser,                 // grid_start
   // responses
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [((VALUE_WIDTH + SUM_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
                                      // new_temperature, then grid_sum
   output logic                       rsp_tlast
);

   localparam int COL_W   = $clog2(MAX_COLS);
   localparam int QWIDTH  = VALUE_WIDTH + COL_W + FLAGS_WIDTH;
   localparam int RSP_DW  = ((VALUE_WIDTH + SUM_WIDTH + 7) / 8) * 8;

   logic                   q_push, q_full, q_pop, q_valid;
   logic [VALUE_WIDTH-1:0] f_value, b_value;
   logic [COL_W-1:0]       f_col, b_col;
   cell_flags_type         f_flags, b_flags;
   logic [QWIDTH-1:0]      q_in, q_out;
   logic [VALUE_WIDTH-1:0] new_temperature;
   logic [SUM_WIDTH-1:0]   grid_sum;

   jfps_front #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLS    (MAX_COLS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_temperature (req_tdata[VALUE_WIDTH-1:0]),
      .req_grid_start  (req_tuser),
      .q_push          (q_push),
      .q_full          (q_full),
      .q_value         (f_value),
      .q_col           (f_col),
      .q_flags         (f_flags)
   );

   assign q_in = {f_flags, f_col, f_value};

   jfps_queue #(
      .WIDTH (QWIDTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_data  (q_out)
   );

   assign b_value = q_out[VALUE_WIDTH-1:0];
   assign b_col   = q_out[VALUE_WIDTH +: COL_W];
   assign b_flags = cell_flags_type'(q_out[QWIDTH-1 -: FLAGS_WIDTH]);

   jfps_back #(
      .MAX_COLS    (MAX_COLS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (q_valid),
      .q_pop               (q_pop),
      .q_value             (b_value),
      .q_col               (b_col),
      .q_flags             (b_flags),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_new_temperature (new_temperature),
      .rsp_grid_sum        (grid_sum),
      .rsp_tlast           (rsp_tlast)
   );

   assign rsp_tdata = RSP_DW'({grid_sum, new_temperature});

endmodule
